[hw/rtl/pds_pkg.sv]
package pds_pkg;

    localparam int POS_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 32;
    localparam int DERIV_W = POS_W + 1;
    localparam int SPD_W   = 16;
    localparam int DRV_W   = 15;
    localparam int SUM_W   = 20;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Product widths: unsigned Q8.8 gain (zero-extended by one bit) times a signed operand
    localparam int PPROP_W  = GAIN_W + 1 + POS_W;
    localparam int PINTEG_W = GAIN_W + 1 + INTEG_W;
    localparam int PDERIV_W = GAIN_W + 1 + DERIV_W;

    // Power sum and the speed before the clamp, both in Q.23
    localparam int POW_W = PINTEG_W + 2;
    localparam int V23_W = POW_W + 1;

    localparam int          ONE_Q15  = 32768;
    localparam logic [23:0] TOP_Q23  = 24'd8388608;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2,
        REG_BASE_SPEED = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [GAIN_W-1:0] base_speed;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [INTEG_W-1:0] integ;
    } t_front;

    typedef struct packed {
        logic signed [PPROP_W-1:0]  p_prop;
        logic signed [PINTEG_W-1:0] p_integ;
        logic signed [PDERIV_W-1:0] p_deriv;
    } t_prod;

    // Clamp a Q.23 speed to 0..1.0 and drop the eight gain fraction bits
    function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [V23_W-1:0] v);
        logic [SPD_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({1'b0, {(V23_W - 25){1'b0}}, TOP_Q23})) begin
            res = SPD_W'(ONE_Q15);
        end else begin
            res = v[23:8];
        end
        return res;
    endfunction

endpackage

[hw/rtl/pds_regs.sv]
module pds_regs
    import pds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= 16'd256;
            r_cfg.gain_integ <= 16'd0;
            r_cfg.gain_deriv <= 16'd5120;
            r_cfg.base_speed <= 16'd32768;
        end else if (wr_en) begin
            unique case (idx)
                REG_GAIN_PROP:  r_cfg.gain_prop  <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG: r_cfg.gain_integ <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV: r_cfg.gain_deriv <= pwdata[GAIN_W-1:0];
                REG_BASE_SPEED: r_cfg.base_speed <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GAIN_PROP:  prdata = PDATA_W'(r_cfg.gain_prop);
            REG_GAIN_INTEG: prdata = PDATA_W'(r_cfg.gain_integ);
            REG_GAIN_DERIV: prdata = PDATA_W'(r_cfg.gain_deriv);
            REG_BASE_SPEED: prdata = PDATA_W'(r_cfg.base_speed);
            default:        prdata = '0;
        endcase
    end

endmodule

[hw/rtl/pds_front.sv]
module pds_front
    import pds_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_pos,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_front                  o_front
);

    logic                        r_valid;
    t_front                      r_front;
    logic signed [POS_W-1:0]     r_prev;
    logic signed [INTEG_W-1:0]   r_integ;
    logic signed [INTEG_W-1:0]   n_integ;
    logic signed [INTEG_W:0]     integ_sum;
    logic signed [DERIV_W-1:0]   deriv;
    logic                        take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_front = r_front;

    // Saturate on signed overflow of the accumulate
    always_comb begin
        integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(i_pos);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                         : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
        deriv = DERIV_W'(i_pos) - DERIV_W'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (!o_stall) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_prev  <= i_pos;
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_front.pos   <= i_pos;
            r_front.deriv <= deriv;
            r_front.integ <= n_integ;
        end
    end

endmodule

[hw/rtl/pds_mult.sv]
module pds_mult
    import pds_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_front i_front,
    output logic   o_valid,
    input  logic   i_stall,
    output t_prod  o_prod
);

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;
    logic  take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        n_prod.p_prop  = $signed({1'b0, i_cfg.gain_prop})  * i_front.pos;
        n_prod.p_integ = $signed({1'b0, i_cfg.gain_integ}) * i_front.integ;
        n_prod.p_deriv = $signed({1'b0, i_cfg.gain_deriv}) * i_front.deriv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod <= n_prod;
        end
    end

endmodule

[hw/rtl/pds_out.sv]
module pds_out
    import pds_pkg::*;
#(
    parameter int RING_DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_prod            i_prod,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [DRV_W-1:0] o_left_drive,
    output logic [DRV_W-1:0] o_right_drive,
    output logic             o_halt
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_RST  = SUM_W'(RING_DEPTH * ONE_Q15);

    logic                     r_valid;
    logic [DRV_W-1:0]         r_left_drive;
    logic [DRV_W-1:0]         r_right_drive;
    logic                     r_halt;
    logic [SPD_W-1:0]         r_ring [RING_DEPTH];
    logic [PTR_W-1:0]         r_ptr;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic signed [POW_W-1:0]  power;
    logic signed [V23_W-1:0]  base23;
    logic [SPD_W-1:0]         left;
    logic [SPD_W-1:0]         right;
    logic                     take;

    assign o_stall       = r_valid && i_stall;
    assign take          = i_valid && !o_stall;
    assign o_valid       = r_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;
    assign o_halt        = r_halt;

    always_comb begin
        power  = POW_W'(i_prod.p_prop) + POW_W'(i_prod.p_integ) + POW_W'(i_prod.p_deriv);
        base23 = $signed({{(V23_W - GAIN_W - 8){1'b0}}, i_cfg.base_speed, 8'b0});
        left   = clamp_speed(base23 - V23_W'(power));
        right  = clamp_speed(base23 + V23_W'(power));
        n_sum  = r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(left);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
            r_sum   <= SUM_RST;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= SPD_W'(ONE_Q15);
            end
        end else begin
            if (!o_stall) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_ring[r_ptr] <= left;
                r_sum         <= n_sum;
                r_ptr         <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_left_drive  <= left[SPD_W-1:1];
            r_right_drive <= right[SPD_W-1:1];
            r_halt        <= (n_sum == '0);
        end
    end

endmodule

[hw/rtl/pid_differential_steer.sv]
// PID steering for a differential-drive line follower. Each transfer on the
// input channel carries one signed Q1.15 line position; each transfer on the
// output channel returns the left and right motor drives (clamped speed,
// halved, Q0.15) and a halt flag, exactly one result per sample and in order.
// The block is a three-stage pipeline: the first stage updates the saturating
// integral and the derivative, the second forms the three gain products, the
// third sums them, clamps both speeds to 0..1.0, updates the ring of recent
// left speeds and registers the result. A sample can enter every cycle while
// the output does not stall, so the sustained rate is then one sample per
// clock. An input transfer loads the first stage, then the products, then
// the result register, from which the result can transfer. A stalled output
// fills all three stages before the input stalls. Halt rises when the sum
// of the last RING_DEPTH left speeds is zero; the ring starts full at 1.0
// after reset. Gains and base speed are written over the APB port (gain_prop
// at 0x0, gain_integ at 0x4, gain_deriv at 0x8, base_speed at 0xC); write
// them only while no sample is in flight.
module pid_differential_steer
    import pds_pkg::*;
#(
    parameter int RING_DEPTH = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // sample channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_line_pos,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [DRV_W-1:0]        o_left_drive,
    output logic [DRV_W-1:0]        o_right_drive,
    output logic                    o_halt
);

    t_cfg   cfg;
    t_front front;
    t_prod  prod;
    logic   front_valid;
    logic   front_stall;
    logic   prod_valid;
    logic   prod_stall;

    // Register file: gains and base speed
    pds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage 1: integral and derivative, advance on each input transfer
    pds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pos   (i_line_pos),
        .o_valid (front_valid),
        .i_stall (front_stall),
        .o_front (front)
    );

    // Stage 2: the three gain products
    pds_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_front (front),
        .o_valid (prod_valid),
        .i_stall (prod_stall),
        .o_prod  (prod)
    );

    // Stage 3: sum, clamp, ring update, result register
    pds_out #(
        .RING_DEPTH (RING_DEPTH)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (prod_valid),
        .o_stall       (prod_stall),
        .i_prod        (prod),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_halt        (o_halt)
    );

endmodule

[test/pid_differential_steer_test.sv]
module pid_differential_steer_test;
    import pds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 1;
    // Cycles without any transfer before the run is declared hung
    localparam int STUCK_LIMIT = 2000;
    // Cycles the result side holds off during the back-pressure test
    localparam int HOLD_CYCLES = 48;
    localparam int SEG_ITEMS   = 105;

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;
    localparam longint TOP_SPEED = 64'sd8388608;

    typedef struct packed {
        logic [DRV_W-1:0] left_drv;
        logic [DRV_W-1:0] right_drv;
        logic             halt;
    } t_drive;

    // Steering predictor plus the queue of drive triples still owed by the block
    class steer_scoreboard #(int DEPTH = 1);
        logic [GAIN_W-1:0]       kp, ki, kd, base;
        logic signed [POS_W-1:0] last_pos;
        longint                  integ;
        logic [SPD_W-1:0]        left_hist[DEPTH];
        int                      hist_idx;
        logic [SUM_W-1:0]        hist_total;
        t_drive                  awaited[$];
        int                      errors;

        function new();
            kp         = 16'd256;
            ki         = 16'd0;
            kd         = 16'd5120;
            base       = 16'(ONE_Q15);
            last_pos   = '0;
            integ      = 0;
            for (int i = 0; i < DEPTH; i++) left_hist[i] = 16'(ONE_Q15);
            hist_idx   = 0;
            hist_total = SUM_W'(DEPTH * ONE_Q15);
            errors     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [GAIN_W-1:0] v);
            case (idx)
                REG_GAIN_PROP:  kp = v;
                REG_GAIN_INTEG: ki = v;
                REG_GAIN_DERIV: kd = v;
                REG_BASE_SPEED: base = v;
            endcase
        endfunction

        function logic [GAIN_W-1:0] reg_value(t_reg_idx idx);
            logic [GAIN_W-1:0] v;
            case (idx)
                REG_GAIN_PROP:  v = kp;
                REG_GAIN_INTEG: v = ki;
                REG_GAIN_DERIV: v = kd;
                default:        v = base;
            endcase
            return v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function logic [SPD_W-1:0] limit_speed(longint v);
            if (v < 0) return '0;
            if (v > TOP_SPEED) return 16'(ONE_Q15);
            return 16'(v >>> 8);
        endfunction

        function void note_sample(logic signed [POS_W-1:0] pos);
            longint           p, d, power, base23;
            logic [SPD_W-1:0] lspd, rspd;
            t_drive           e;
            p = pos;
            d = p - longint'(last_pos);
            integ = integ + p;
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            if (integ < INTEG_MIN) integ = INTEG_MIN;
            last_pos = pos;
            power  = longint'(kp) * p + longint'(ki) * integ + longint'(kd) * d;
            base23 = longint'(base) * 256;
            lspd = limit_speed(base23 - power);
            rspd = limit_speed(base23 + power);
            hist_total = hist_total - SUM_W'(left_hist[hist_idx]) + SUM_W'(lspd);
            left_hist[hist_idx] = lspd;
            hist_idx = (hist_idx + 1) % DEPTH;
            e.left_drv  = lspd[SPD_W-1:1];
            e.right_drv = rspd[SPD_W-1:1];
            e.halt      = (hist_total == '0);
            awaited.push_back(e);
        endfunction

        task check_result(logic [DRV_W-1:0] l, logic [DRV_W-1:0] r, logic h);
            t_drive e;
            if (awaited.size() == 0) begin
                report($sformatf("drive l=%0d r=%0d halt=%0b with nothing awaited", l, r, h));
            end else begin
                e = awaited.pop_front();
                if (l !== e.left_drv)
                    report($sformatf("left_drive got %0d want %0d", l, e.left_drv));
                if (r !== e.right_drv)
                    report($sformatf("right_drive got %0d want %0d", r, e.right_drv));
                if (h !== e.halt)
                    report($sformatf("halt got %0b want %0b", h, e.halt));
            end
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [POS_W-1:0] i_line_pos;
    logic                    o_valid;
    logic                    i_stall;
    logic [DRV_W-1:0]        o_left_drive;
    logic [DRV_W-1:0]        o_right_drive;
    logic                    o_halt;

    steer_scoreboard #(RING_DEPTH) sb;

    // Idle percentages of the sample side and the result side
    int send_pct;
    int recv_pct;
    // Raised by the stimulus to request one long hold-off on the result side
    bit hold_go;
    int stuck_cycles;

    pid_differential_steer #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_line_pos   (i_line_pos),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_drive (o_left_drive),
        .o_right_drive(o_right_drive),
        .o_halt       (o_halt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one sample and hold it until the block takes it, then maybe idle
    task send_sample(logic signed [POS_W-1:0] pos);
        i_valid    <= 1'b1;
        i_line_pos <= pos;
        do @(posedge i_clk); while (o_stall);
        // transfer happened at this edge
        sb.note_sample(pos);
        if ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_pct);
        end
    endtask

    // Drop the sample side and wait until every owed result has come back
    task settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Read one register over APB and compare with the predictor's copy
    task check_reg(t_reg_idx idx);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(sb.reg_value(idx)))
            sb.report($sformatf("register %s reads %0h want %0h",
                                idx.name(), got, sb.reg_value(idx)));
        @(posedge i_clk);
    endtask

    // Write one register with junk in the upper bits, then read it back
    task write_reg(t_reg_idx idx, logic [GAIN_W-1:0] v);
        logic [PDATA_W-1:0] data;
        data = {16'($urandom()), v};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
        check_reg(idx);
    endtask

    task load_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                    logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] base);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_BASE_SPEED, base);
    endtask

    // Mix of rail values, small positions, a drifting track and full-range noise
    function automatic logic signed [POS_W-1:0] pick_pos(logic signed [POS_W-1:0] near);
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 32767 : -32768;
            1:       v = $urandom_range(0, 1) ? 0 : -1;
            2, 3, 4: v = int'(near) + int'($urandom_range(0, 512)) - 256;
            5, 6:    v = int'($urandom_range(0, 4095)) - 2048;
            default: v = int'($signed(16'($urandom())));
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return POS_W'(v);
    endfunction

    // Result side: take drives whenever the block offers them and we do not stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_left_drive, o_right_drive, o_halt);
    end

    // Result side stall pattern, with one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    // Watchdog: any transfer on either channel or the APB port resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (psel && penable && pready) || (i_valid && !o_stall) ||
            (o_valid && !i_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic signed [POS_W-1:0] walk_pos;
        logic signed [POS_W-1:0] pos;
        sb           = new();
        send_pct     = 0;
        recv_pct     = 0;
        hold_go      = 1'b0;
        stuck_cycles = 0;
        walk_pos     = '0;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_valid    <= 1'b0;
        i_line_pos <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of all registers
        for (int i = 0; i < 4; i++) check_reg(t_reg_idx'(i));

        // Reset gains: rails and unit steps, the derivative term dominates
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        settle();

        // Maximum gains, zero cruise: one side pinned at zero raises halt
        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        settle();

        // Cruise above 1.0 with no steering: both speeds clamp at the top
        load_gains(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'sd0);
        send_sample(16'sd5);
        settle();

        // Moderate gains at half speed, with small and large positions
        load_gains(16'd256, 16'd1, 16'd128, 16'd16384);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        send_sample(16'sd20000);
        send_sample(-16'sd20000);
        send_sample(16'sd0);
        settle();

        // Random segments: receiver idles more, then sender idles more, then neither
        for (int seg = 0; seg < 6; seg++) begin
            settle();
            case (seg / 2)
                0: begin send_pct = 27; recv_pct = 52; end
                1: begin send_pct = 52; recv_pct = 27; end
                default: begin send_pct = 0; recv_pct = 0; end
            endcase
            if ($urandom_range(0, 3) == 0)
                load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()));
            else
                load_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 4096)), 16'($urandom_range(0, 32768)));
            // Long hold-off on the result side while samples keep coming
            if (seg == 4) hold_go = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pos = pick_pos(walk_pos);
                walk_pos = pos;
                send_sample(pos);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
